/* rtl/ground_height_ray_triangle_query_unit_macros.svh */
// Assertion macros used by the query unit controller.
`ifndef GROUND_HEIGHT_RAY_TRIANGLE_QUERY_UNIT_MACROS_SVH
`define GROUND_HEIGHT_RAY_TRIANGLE_QUERY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GHQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GHQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GHQ_ASSERT_SAME(label, ante, cons)
`define GHQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/ghq_pkg.sv */
package ghq_pkg;

    localparam int MAX_TRIANGLES_DEF = 1024;
    localparam int COORD_W = 24;
    localparam int DIFF_W = 25;
    localparam int PROD_W = 50;
    localparam int EDGE_W = 51;
    localparam int MAG_W = 50;
    localparam int HALF_W = 25;
    localparam int DEN_W = 52;
    localparam int PART_W = 50;
    localparam int NUM_W = 77;
    localparam int REM_W = 53;
    localparam int QUO_W = 25;
    localparam int YC_W = 26;
    localparam int COUNT_W = 11;
    localparam int IDX_W = 10;
    localparam int CORNER_W = 2;
    localparam int CORNER_DATA_W = 3 * COORD_W;
    localparam logic signed [YC_W-1:0] SEG_TOP = 26'sd2560000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Cycles after an address change at which stage results are settled; DIV_LAST is the last divider step.
    localparam logic [2:0] STEP_TEST = 3'd5;
    localparam logic [2:0] STEP_NUM = 3'd7;
    localparam logic [4:0] DIV_LAST = 5'd24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic wr;
        logic q_load;
        logic div_init;
        logic div_step;
        logic res_load;
        logic res_hit;
    } ghq_cmd_t;

    typedef struct packed {
        logic in_tri;
        logic seg_ok;
    } ghq_status_t;

endpackage

/* rtl/ghq_ram.sv */
module ghq_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ghq_datapath.sv */
module ghq_datapath #(
    parameter int MAX_TRIANGLES = ghq_pkg::MAX_TRIANGLES_DEF,
    parameter int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1
) (
    input  logic                              clk,
    input  ghq_pkg::ghq_cmd_t                 cmd,
    output ghq_pkg::ghq_status_t              status,
    input  logic [AW-1:0]                     rd_addr,
    input  logic [ghq_pkg::IDX_W-1:0]         tri_index,
    input  logic [ghq_pkg::CORNER_W-1:0]      corner,
    input  logic signed [ghq_pkg::COORD_W-1:0] vert_x,
    input  logic signed [ghq_pkg::COORD_W-1:0] vert_y,
    input  logic signed [ghq_pkg::COORD_W-1:0] vert_z,
    input  logic signed [ghq_pkg::COORD_W-1:0] query_x,
    input  logic signed [ghq_pkg::COORD_W-1:0] query_z,
    output logic signed [ghq_pkg::COORD_W-1:0] height,
    output logic [ghq_pkg::IDX_W-1:0]         hit_triangle
);

    localparam int CW = (AW > ghq_pkg::IDX_W) ? AW + 1 : ghq_pkg::IDX_W + 1;

    logic [ghq_pkg::CORNER_DATA_W-1:0] rdata [3];
    logic slot_ok;

    logic signed [ghq_pkg::COORD_W-1:0] qx_reg, qz_reg;
    logic signed [ghq_pkg::COORD_W-1:0] cx [3];
    logic signed [ghq_pkg::COORD_W-1:0] cy [3];
    logic signed [ghq_pkg::COORD_W-1:0] cz [3];

    logic signed [ghq_pkg::DIFF_W-1:0] dbx_reg [3];
    logic signed [ghq_pkg::DIFF_W-1:0] dqz_reg [3];
    logic signed [ghq_pkg::DIFF_W-1:0] dbz_reg [3];
    logic signed [ghq_pkg::DIFF_W-1:0] dqx_reg [3];
    logic signed [ghq_pkg::PROD_W-1:0] pa_reg [3];
    logic signed [ghq_pkg::PROD_W-1:0] pb_reg [3];
    logic signed [ghq_pkg::EDGE_W-1:0] w_reg [3];
    logic signed [ghq_pkg::EDGE_W-1:0] wabs [3];
    logic [ghq_pkg::MAG_W-1:0] mag_reg [3];
    logic [ghq_pkg::DEN_W-1:0] den_reg;
    logic in_tri_reg;
    logic signed [ghq_pkg::PART_W-1:0] lo_reg [3];
    logic signed [ghq_pkg::PART_W-1:0] hi_reg [3];
    logic signed [ghq_pkg::NUM_W-1:0] num_reg;

    logic neg_reg;
    logic [ghq_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [ghq_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [ghq_pkg::NUM_W-1:0] num_mag;
    logic [ghq_pkg::REM_W-1:0] trial;
    logic ge;
    logic signed [ghq_pkg::YC_W-1:0] yc;
    logic rnz;

    logic signed [ghq_pkg::COORD_W-1:0] height_reg;
    logic [ghq_pkg::IDX_W-1:0] hit_tri_reg;

    function automatic logic signed [ghq_pkg::DIFF_W-1:0] DIFF_W_EXT(
        input logic signed [ghq_pkg::COORD_W-1:0] v);
        return ghq_pkg::DIFF_W'(v);
    endfunction

    assign slot_ok = (CW'(tri_index) < CW'(MAX_TRIANGLES)) && (corner != 2'd3);

    // One memory per corner; each entry holds {z, y, x} of that corner.
    for (genvar k = 0; k < 3; k++)
    begin : g_corner
        ghq_ram #(
            .WIDTH(ghq_pkg::CORNER_DATA_W),
            .DEPTH(MAX_TRIANGLES),
            .ADDR_W(AW)
        ) u_ram (
            .clk  (clk),
            .we   (cmd.wr && slot_ok && (corner == 2'(k))),
            .waddr(AW'(tri_index)),
            .wdata({vert_z, vert_y, vert_x}),
            .raddr(rd_addr),
            .rdata(rdata[k])
        );
        assign cx[k] = rdata[k][ghq_pkg::COORD_W-1:0];
        assign cy[k] = rdata[k][2*ghq_pkg::COORD_W-1:ghq_pkg::COORD_W];
        assign cz[k] = rdata[k][3*ghq_pkg::COORD_W-1:2*ghq_pkg::COORD_W];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
        begin
            qx_reg <= query_x;
            qz_reg <= query_z;
        end
    end

    // Free-running stages; they settle while the triangle address holds.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dbx_reg[i] <= DIFF_W_EXT(cx[(i + 1) % 3]) - DIFF_W_EXT(cx[i]);
            dbz_reg[i] <= DIFF_W_EXT(cz[(i + 1) % 3]) - DIFF_W_EXT(cz[i]);
            dqx_reg[i] <= DIFF_W_EXT(qx_reg) - DIFF_W_EXT(cx[i]);
            dqz_reg[i] <= DIFF_W_EXT(qz_reg) - DIFF_W_EXT(cz[i]);
            pa_reg[i] <= ghq_pkg::PROD_W'(dbx_reg[i] * dqz_reg[i]);
            pb_reg[i] <= ghq_pkg::PROD_W'(dbz_reg[i] * dqx_reg[i]);
            w_reg[i] <= ghq_pkg::EDGE_W'(pa_reg[i]) - ghq_pkg::EDGE_W'(pb_reg[i]);
            mag_reg[i] <= wabs[i][ghq_pkg::MAG_W-1:0];
            lo_reg[i] <= ghq_pkg::PART_W'($signed({1'b0, mag_reg[i][ghq_pkg::HALF_W-1:0]})
                         * cy[(i + 2) % 3]);
            hi_reg[i] <= ghq_pkg::PART_W'($signed({1'b0,
                         mag_reg[i][ghq_pkg::MAG_W-1:ghq_pkg::HALF_W]}) * cy[(i + 2) % 3]);
        end
        den_reg <= ghq_pkg::DEN_W'(wabs[0][ghq_pkg::MAG_W-1:0])
                 + ghq_pkg::DEN_W'(wabs[1][ghq_pkg::MAG_W-1:0])
                 + ghq_pkg::DEN_W'(wabs[2][ghq_pkg::MAG_W-1:0]);
        in_tri_reg <= ((w_reg[0] > 0) && (w_reg[1] > 0) && (w_reg[2] > 0))
                   || ((w_reg[0] < 0) && (w_reg[1] < 0) && (w_reg[2] < 0));
        num_reg <= (ghq_pkg::NUM_W'(hi_reg[0]) <<< ghq_pkg::HALF_W) + ghq_pkg::NUM_W'(lo_reg[0])
                 + (ghq_pkg::NUM_W'(hi_reg[1]) <<< ghq_pkg::HALF_W) + ghq_pkg::NUM_W'(lo_reg[1])
                 + (ghq_pkg::NUM_W'(hi_reg[2]) <<< ghq_pkg::HALF_W) + ghq_pkg::NUM_W'(lo_reg[2]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wabs[i] = w_reg[0][ghq_pkg::EDGE_W-1] ? -w_reg[i] : w_reg[i];
        end
    end

    // Restoring divider, one quotient bit per step; the quotient fits in QUO_W bits.
    assign num_mag = num_reg[ghq_pkg::NUM_W-1] ? ghq_pkg::NUM_W'(-num_reg)
                                               : ghq_pkg::NUM_W'(num_reg);
    assign trial = {rem_reg[ghq_pkg::REM_W-2:0], quo_reg[ghq_pkg::QUO_W-1]};
    assign ge = trial >= ghq_pkg::REM_W'(den_reg);

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.div_init)
        begin
            rem_next = ghq_pkg::REM_W'(num_mag >> ghq_pkg::QUO_W);
            quo_next = num_mag[ghq_pkg::QUO_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_next = ge ? trial - ghq_pkg::REM_W'(den_reg) : trial;
            quo_next = {quo_reg[ghq_pkg::QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.div_init)
        begin
            neg_reg <= num_reg[ghq_pkg::NUM_W-1];
        end
    end

    assign rnz = |rem_reg;
    assign yc = neg_reg ? -$signed({1'b0, quo_reg}) - ghq_pkg::YC_W'(rnz)
                        : $signed({1'b0, quo_reg});

    assign status.in_tri = in_tri_reg;
    assign status.seg_ok = (yc < ghq_pkg::SEG_TOP)
                        && ((yc > -ghq_pkg::SEG_TOP) || ((yc == -ghq_pkg::SEG_TOP) && rnz));

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            height_reg <= cmd.res_hit ? yc[ghq_pkg::COORD_W-1:0] : '0;
            hit_tri_reg <= cmd.res_hit ? ghq_pkg::IDX_W'(rd_addr) : '0;
        end
    end

    assign height = height_reg;
    assign hit_triangle = hit_tri_reg;

endmodule

/* rtl/ghq_ctrl.sv */
`include "ground_height_ray_triangle_query_unit_macros.svh"

module ghq_ctrl #(
    parameter int MAX_TRIANGLES = ghq_pkg::MAX_TRIANGLES_DEF,
    parameter int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_hit,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ghq_pkg::COUNT_W-1:0]  cfg_data,
    output ghq_pkg::ghq_cmd_t            cmd,
    input  ghq_pkg::ghq_status_t         status,
    output logic [AW-1:0]                rd_addr
);

    localparam int TW = $clog2(MAX_TRIANGLES + 1);
    localparam int CMPW = (TW > ghq_pkg::COUNT_W) ? TW : ghq_pkg::COUNT_W;

    ghq_pkg::state_t state_reg, state_next;
    logic [ghq_pkg::COUNT_W-1:0] count_reg;
    logic [TW-1:0] scan_reg, scan_next, scan_limit;
    logic [TW-1:0] t_reg, t_next;
    logic [2:0] step_reg, step_next;
    logic [4:0] div_cnt_reg, div_cnt_next;
    logic found_reg, found_next;
    logic out_valid_reg, out_valid_next;
    logic last_tri;
    logic out_free;

    assign scan_limit = (CMPW'(count_reg) > CMPW'(MAX_TRIANGLES))
                      ? TW'(MAX_TRIANGLES) : TW'(count_reg);
    assign last_tri = (t_reg == scan_reg - TW'(1));
    assign out_free = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ghq_pkg::ST_IDLE;
            count_reg <= '0;
            scan_reg <= '0;
            t_reg <= '0;
            step_reg <= '0;
            div_cnt_reg <= '0;
            found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            scan_reg <= scan_next;
            t_reg <= t_next;
            step_reg <= step_next;
            div_cnt_reg <= div_cnt_next;
            found_reg <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        scan_next = scan_reg;
        t_next = t_reg;
        step_next = step_reg;
        div_cnt_next = div_cnt_reg;
        found_next = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready = 1'b0;
        cmd = '0;
        case (state_reg)
            ghq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command == ghq_pkg::CMD_LOAD)
                    begin
                        cmd.wr = 1'b1;
                    end
                    else
                    begin
                        cmd.q_load = 1'b1;
                        scan_next = scan_limit;
                        t_next = '0;
                        step_next = '0;
                        found_next = 1'b0;
                        state_next = (scan_limit == '0) ? ghq_pkg::ST_DONE : ghq_pkg::ST_SCAN;
                    end
                end
            end
            ghq_pkg::ST_SCAN:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == ghq_pkg::STEP_TEST && !status.in_tri)
                begin
                    step_next = '0;
                    if (last_tri)
                    begin
                        state_next = ghq_pkg::ST_DONE;
                    end
                    else
                    begin
                        t_next = t_reg + TW'(1);
                    end
                end
                else if (step_reg == ghq_pkg::STEP_NUM)
                begin
                    cmd.div_init = 1'b1;
                    div_cnt_next = '0;
                    state_next = ghq_pkg::ST_DIV;
                end
            end
            ghq_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == ghq_pkg::DIV_LAST)
                begin
                    state_next = ghq_pkg::ST_CHECK;
                end
            end
            ghq_pkg::ST_CHECK:
            begin
                step_next = '0;
                if (status.seg_ok)
                begin
                    found_next = 1'b1;
                    state_next = ghq_pkg::ST_DONE;
                end
                else if (last_tri)
                begin
                    state_next = ghq_pkg::ST_DONE;
                end
                else
                begin
                    t_next = t_reg + TW'(1);
                    state_next = ghq_pkg::ST_SCAN;
                end
            end
            ghq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_hit = found_reg;
                    out_valid_next = 1'b1;
                    state_next = ghq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ghq_pkg::ST_IDLE;
            end
        endcase
    end

    logic hit_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_flag_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            hit_flag_reg <= found_reg;
        end
    end

    assign rd_addr = t_reg[AW-1:0];
    assign out_valid = out_valid_reg;
    assign out_hit = hit_flag_reg;

    `GHQ_ASSERT_SAME(a_scan_in_range, state_reg == ghq_pkg::ST_SCAN, t_reg < scan_reg)
    `GHQ_ASSERT_SAME(a_result_slot_free, cmd.res_load, !out_valid_reg || out_ready)
    `GHQ_ASSERT_NEXT(a_query_starts, in_valid && in_ready && command == ghq_pkg::CMD_QUERY, state_reg != ghq_pkg::ST_IDLE)
    `GHQ_ASSERT_SAME(a_div_bound, state_reg == ghq_pkg::ST_DIV, div_cnt_reg <= ghq_pkg::DIV_LAST)

endmodule

/* rtl/ground_height_ray_triangle_query_unit.sv */
// Channel   Direction  Words
// s_axis    in         corner load or ground-height query, kind in tuser
// m_axis    out        one word per query: hit flag in tuser, height and triangle
// cfg       in         triangle_count, 11 bits
//
// A load returns no word. A query walks the triangles in order, testing each
// against the edge test with the per-triangle stage sequence; a candidate also
// runs the one-bit-a-step divider and the segment check. The query stalls only
// if the previous word is still waiting on m_axis. The corner memories need no
// clearing after reset.
module ground_height_ray_triangle_query_unit #(
    parameter int MAX_TRIANGLES = ghq_pkg::MAX_TRIANGLES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tri_index, corner, vert_x, vert_y, vert_z, query_x, query_z
    input  logic [135:0] s_axis_tdata,
    // command
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // height, hit_triangle
    output logic [39:0]  m_axis_tdata,
    // hit
    output logic         m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [10:0]  cfg_data
);

    localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

    ghq_pkg::ghq_cmd_t cmd;
    ghq_pkg::ghq_status_t status;
    logic [AW-1:0] rd_addr;
    logic signed [ghq_pkg::COORD_W-1:0] height;
    logic [ghq_pkg::IDX_W-1:0] hit_triangle;

    ghq_ctrl #(
        .MAX_TRIANGLES(MAX_TRIANGLES),
        .AW(AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .command  (s_axis_tuser),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_hit  (m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .rd_addr  (rd_addr)
    );

    ghq_datapath #(
        .MAX_TRIANGLES(MAX_TRIANGLES),
        .AW(AW)
    ) u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .status      (status),
        .rd_addr     (rd_addr),
        .tri_index   (s_axis_tdata[9:0]),
        .corner      (s_axis_tdata[11:10]),
        .vert_x      (s_axis_tdata[35:12]),
        .vert_y      (s_axis_tdata[59:36]),
        .vert_z      (s_axis_tdata[83:60]),
        .query_x     (s_axis_tdata[107:84]),
        .query_z     (s_axis_tdata[131:108]),
        .height      (height),
        .hit_triangle(hit_triangle)
    );

    assign m_axis_tdata = {6'd0, hit_triangle, height};

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int SLOTS = 1024;
    localparam int FILL = 16;
    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEG_LIMIT = 2560000;

    typedef struct {
        bit          hit;
        logic [23:0] height;
        logic [9:0]  tri_no;
    } ground_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [10:0]  cfg_data;

    // Mirror of the corner memories and the count register.
    int             mesh_x [0:3*SLOTS-1];
    int             mesh_y [0:3*SLOTS-1];
    int             mesh_z [0:3*SLOTS-1];
    int             scan_count;
    ground_result_t pending_heights[$];
    int             errors;
    bit             no_idle;
    bit             hold_req;
    int             quiet_cycles;

    ground_height_ray_triangle_query_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int sx24(int v);
        return {{8{v[23]}}, v[23:0]};
    endfunction

    function automatic longint edge_weight(longint ax, longint az, longint bx, longint bz,
                                           longint px, longint pz);
        return (bx - ax) * (pz - az) - (bz - az) * (px - ax);
    endfunction

    function automatic ground_result_t ground_height(int px, int pz);
        ground_result_t res;
        longint w0, w1, w2;
        logic signed [127:0] num, den, quo, rem;
        int b;
        res.hit = 0;
        res.height = '0;
        res.tri_no = '0;
        for (int t = 0; t < ((scan_count > SLOTS) ? SLOTS : scan_count); t++)
        begin
            b = 3 * t;
            w0 = edge_weight(mesh_x[b], mesh_z[b], mesh_x[b+1], mesh_z[b+1], px, pz);
            w1 = edge_weight(mesh_x[b+1], mesh_z[b+1], mesh_x[b+2], mesh_z[b+2], px, pz);
            w2 = edge_weight(mesh_x[b+2], mesh_z[b+2], mesh_x[b], mesh_z[b], px, pz);
            if (!((w0 > 0 && w1 > 0 && w2 > 0) || (w0 < 0 && w1 < 0 && w2 < 0)))
                continue;
            if (w0 < 0)
            begin
                w0 = -w0;
                w1 = -w1;
                w2 = -w2;
            end
            num = w1;
            num = num * mesh_y[b];
            quo = w2;
            num = num + quo * mesh_y[b+1];
            quo = w0;
            num = num + quo * mesh_y[b+2];
            den = w0 + w1 + w2;
            quo = num / den;
            rem = num % den;
            // Round the height toward minus infinity.
            if (num < 0 && rem != 0)
                quo = quo - 1;
            if (!(quo < SEG_LIMIT && (quo > -SEG_LIMIT || (quo == -SEG_LIMIT && rem != 0))))
                continue;
            res.hit = 1;
            res.height = quo[23:0];
            res.tri_no = t[9:0];
            return res;
        end
        return res;
    endfunction

    task automatic send_word(logic command, int idx, int crn, int vx, int vy, int vz,
                             int qx, int qz);
        if (!no_idle)
            while ($urandom_range(99) < 23)
            begin
                s_axis_tvalid = 0;
                @(negedge clk);
            end
        s_axis_tvalid = 1;
        s_axis_tuser = command;
        s_axis_tdata = {4'b0, qz[23:0], qx[23:0], vz[23:0], vy[23:0], vx[23:0],
                        crn[1:0], idx[9:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (command == ghq_pkg::CMD_QUERY)
            pending_heights.push_back(ground_height(sx24(qx), sx24(qz)));
        else if (crn < 3)
        begin
            mesh_x[3*idx+crn] = sx24(vx);
            mesh_y[3*idx+crn] = sx24(vy);
            mesh_z[3*idx+crn] = sx24(vz);
        end
        @(negedge clk);
        s_axis_tvalid = 0;
    endtask

    task automatic load_corner(int idx, int crn, int vx, int vy, int vz);
        send_word(ghq_pkg::CMD_LOAD, idx, crn, vx, vy, vz, $urandom, $urandom);
    endtask

    task automatic query(int qx, int qz);
        send_word(ghq_pkg::CMD_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom,
                  qx, qz);
    endtask

    task automatic load_random_triangle(int idx);
        int cx, cz;
        cx = $urandom_range(0, 8388608) - 4194304;
        cz = $urandom_range(0, 8388608) - 4194304;
        for (int c = 0; c < 3; c++)
            if ($urandom_range(9) == 0)
                load_corner(idx, c, sx24($urandom), sx24($urandom), sx24($urandom));
            else
                load_corner(idx, c, cx + $urandom_range(0, 131072) - 65536,
                            ($urandom_range(3) == 0) ? sx24($urandom)
                                : $urandom_range(0, 4000000) - 2000000,
                            cz + $urandom_range(0, 131072) - 65536);
    endtask

    // Aim at the middle of a scanned triangle so that most queries land on one.
    task automatic query_random;
        int t, b;
        int lim;
        lim = (scan_count > SLOTS) ? SLOTS : scan_count;
        if (lim == 0 || $urandom_range(9) < 3)
            query(sx24($urandom), sx24($urandom));
        else
        begin
            t = $urandom_range(0, lim - 1);
            b = 3 * t;
            query((mesh_x[b] + mesh_x[b+1] + mesh_x[b+2]) / 3
                      + int'($urandom_range(0, 16)) - 8,
                  (mesh_z[b] + mesh_z[b+1] + mesh_z[b+2]) / 3
                      + int'($urandom_range(0, 16)) - 8);
        end
    endtask

    task automatic wait_idle;
        while (pending_heights.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_count(int value);
        wait_idle();
        cfg_valid = 1;
        cfg_data = value[10:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        scan_count = value;
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic test_empty_scan;
        query(0, 0);
        query(sx24($urandom), sx24($urandom));
    endtask

    task automatic test_fill_mesh;
        for (int t = 0; t < FILL; t++)
            load_random_triangle(t);
        write_count(FILL);
        query_random();
        query_random();
        query_random();
        query(-8388608, 8388607);
    endtask

    task automatic test_directed;
        // Plateau above the segment, then a flat floor under the same area.
        for (int c = 0; c < 3; c++)
        begin
            load_corner(0, c, (c == 1) ? 2560 : 0, 8000000, (c == 2) ? 2560 : 0);
            load_corner(1, c, (c == 1) ? 2560 : 0, 25600, (c == 2) ? 2560 : 0);
            // Floor exactly at the bottom end of the segment.
            load_corner(2, c, 100000 + ((c == 1) ? 2560 : 0), -2560000,
                        (c == 2) ? 2560 : 0);
            // Collinear in xz: a vertical sliver.
            load_corner(3, c, 200000 + 256 * c, 1000 * c, 256 * c);
        end
        load_corner(4, 0, -8388608, -1000000, -8388608);
        load_corner(4, 1, 8388607, 2000000, -8388608);
        load_corner(4, 2, -8388608, 500, 8388607);
        // Clockwise winding.
        load_corner(5, 0, 300000, -1234, 0);
        load_corner(5, 1, 300000, -1234, 2560);
        load_corner(5, 2, 302560, 700, 0);
        // A corner index of three must leave triangle 1 alone.
        load_corner(1, 3, 8388607, -8388608, 8388607);
        write_count(6);
        query(256, 256);
        query(0, 256);
        query(0, 0);
        query(100256, 256);
        query(200256, 256);
        query(300256, 256);
        query(-8388608, 0);
        query(-8388607, -8388607);
        query(8388607, 8388607);
    endtask

    task automatic test_random_traffic;
        for (int p = 0; p < 4; p++)
        begin
            write_count((p == 2) ? FILL : $urandom_range(1, FILL));
            no_idle = (p == 3);
            if (p == 1)
                hold_req = 1;
            for (int n = 0; n < 10; n++)
                if ($urandom_range(3) == 0)
                begin
                    if ($urandom_range(19) == 0)
                        load_corner($urandom_range(0, SLOTS - 1), 3, sx24($urandom),
                                    sx24($urandom), sx24($urandom));
                    else
                        load_random_triangle($urandom_range(0, FILL - 1));
                end
                else
                    query_random();
            no_idle = 0;
        end
    endtask

    always @(negedge clk)
    begin : output_pacing
        if (hold_req)
        begin
            m_axis_tready = 0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_req = 0;
        end
        m_axis_tready = no_idle ? 1'b1 : ($urandom_range(99) >= 23);
    end

    always @(posedge clk)
    begin : result_check
        ground_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_heights.size() == 0)
            begin
                $display("%0t: unexpected word hit=%0d height=%h tri=%0d", $time,
                         m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[33:24]);
                errors++;
            end
            else
            begin
                exp_res = pending_heights.pop_front();
                if (m_axis_tuser !== exp_res.hit || m_axis_tdata[23:0] !== exp_res.height
                    || m_axis_tdata[33:24] !== exp_res.tri_no)
                begin
                    $display("%0t: expected hit=%0d height=%h tri=%0d, got hit=%0d height=%h tri=%0d",
                             $time, exp_res.hit, exp_res.height, exp_res.tri_no,
                             m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[33:24]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = 0;
        m_axis_tready = 0;
        cfg_valid = 0;
        cfg_data = '0;
        scan_count = 0;
        errors = 0;
        no_idle = 0;
        hold_req = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_empty_scan();
        test_fill_mesh();
        test_directed();
        test_random_traffic();
        while (pending_heights.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0 && pending_heights.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
